// ===== hw/rtl/sads_pkg.sv =====
// Shared types, sizes and codes for the suffix automaton block.
// No dependencies; the top level, the core and the checker import this package.
`timescale 1ns / 1ps
`default_nettype none
package sads_pkg;

  localparam int unsigned MaxLen     = 4096;
  localparam int unsigned MaxNodes   = 8192;
  localparam int unsigned LogDepth   = 32768;
  localparam int unsigned Alphabet   = 26;
  localparam int unsigned TransWords = MaxNodes * Alphabet;

  localparam int unsigned NodeW = $clog2(MaxNodes);
  localparam int unsigned LenW  = $clog2(MaxLen + 1);
  localparam int unsigned TrAw  = $clog2(TransWords);
  localparam int unsigned SlotW = $clog2(TransWords + MaxNodes);
  localparam int unsigned LogAw = $clog2(LogDepth);
  localparam int unsigned TopW  = LogAw + 1;
  localparam int unsigned ChW   = $clog2(Alphabet);
  localparam int unsigned KW    = $clog2(Alphabet + 1);
  localparam int unsigned LetW  = 5;
  localparam int unsigned TotW  = 24;
  localparam int unsigned ErrW  = 2;
  localparam int unsigned LogW  = SlotW + NodeW;

  // operation codes
  localparam logic OpAppend = 1'b0;
  localparam logic OpUndo   = 1'b1;

  // error codes
  localparam logic [ErrW-1:0] ErrOk    = 2'd0;
  localparam logic [ErrW-1:0] ErrEmpty = 2'd1;
  localparam logic [ErrW-1:0] ErrFull  = 2'd2;

  typedef enum logic [4:0] {
    S_IDLE, S_ALEN, S_CLR, S_W1RD, S_W1CK, S_QCK, S_CPY, S_CLNK, S_CLNK2, S_XLNK,
    S_W2RD, S_W2CK, S_AFIN, S_UHDR, S_UPOP, S_URST, S_USUBA, S_USUBB, S_UNEXT,
    S_ULAST, S_DONE
  } state_e;

  typedef struct packed {
    logic            op;
    logic [LetW-1:0] letter;
  } req_t;

  typedef struct packed {
    logic [TotW-1:0] count;
    logic [ErrW-1:0] err;
  } res_t;

  // word address of a transition: node * Alphabet + letter
  function automatic logic [TrAw-1:0] trans_addr(input logic [NodeW-1:0] node,
                                                 input logic [ChW-1:0] ch);
    return TrAw'(node) * TrAw'(Alphabet) + TrAw'(ch);
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/suffix_automaton_distinct_substrings.sv =====
// Top level: stream handshake, result output register and the automaton core.
// Depends on sads_pkg and sads_core.
`timescale 1ns / 1ps
`default_nettype none
// Online suffix automaton over 26 letters with undo. Each input transaction is an
// append (tuser = 0, letter in tdata) or an undo (tuser = 1) and yields one output
// transaction with the count of distinct nonempty substrings of the current string
// and an error code (1: undo on empty string, 2: append when full). Items run one at
// a time through a sequencer around state memories with one read port and a registered
// read. An append walks the suffix links and clears the new node's 26-word row, and
// copies a row when a node is cloned; an undo restores each logged word, twice over
// for a clone. A finished result waits in the output register while the next item
// starts.
module suffix_automaton_distinct_substrings (
  input  wire        clk_i,
  input  wire        rst_ni,
  input  wire        s_axis_tvalid,
  output logic       s_axis_tready,
  input  wire [7:0]  s_axis_tdata,   // [4:0] letter
  input  wire [0:0]  s_axis_tuser,   // [0] operation
  output logic       m_axis_tvalid,
  input  wire        m_axis_tready,
  output logic [23:0] m_axis_tdata,  // [23:0] distinct_count
  output logic [1:0]  m_axis_tuser   // [1:0] error
);
  import sads_pkg::*;

  req_t        req;
  res_t        res, res_q;
  logic        idle, res_valid, res_ready, out_valid_q;

  assign req.op     = s_axis_tuser[0];
  assign req.letter = s_axis_tdata[LetW-1:0];
  assign s_axis_tready = idle;

  sads_core u_core (
    .clk_i, .rst_ni,
    .start_i     (s_axis_tvalid && idle),
    .req_i       (req),
    .idle_o      (idle),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res)
  );

  // hold the result until the sink takes it
  assign res_ready = !out_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) res_q <= res;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = res_q.count;
  assign m_axis_tuser  = res_q.err;

endmodule
`default_nettype wire

// ===== hw/rtl/sads_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module sads_ram #(
  parameter int unsigned Depth = 16,
  parameter int unsigned Width = 8
) (
  input  wire                     clk_i,
  input  wire                     we_i,
  input  wire [$clog2(Depth)-1:0] waddr_i,
  input  wire [Width-1:0]         wdata_i,
  input  wire [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]        rdata_o
);

  logic [Width-1:0] mem [Depth];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule
`default_nettype wire

// ===== hw/rtl/sads_core.sv =====
// Sequencer and state memories of the suffix automaton: append, undo, log replay.
// Depends on sads_pkg and sads_ram.
`timescale 1ns / 1ps
`default_nettype none
module sads_core (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 start_i,
  input  sads_pkg::req_t      req_i,
  output logic                idle_o,
  output logic                res_valid_o,
  input  wire                 res_ready_i,
  output sads_pkg::res_t      res_o
);
  import sads_pkg::*;

  state_e st_q, st_d;
  logic [ChW-1:0]   c_q, c_d;
  logic [NodeW-1:0] x_q, x_d, y_q, y_d, p_q, p_d, q_q, q_d, nc_q, nc_d, last_q, last_d;
  logic [LenW-1:0]  lenx_q, lenx_d, lenp_q, lenp_d, sub_q, sub_d, lennc_q, lennc_d;
  logic [KW-1:0]    k_q, k_d;
  logic [TopW-1:0]  cnt_q, cnt_d, npop_q, npop_d, top_q, top_d;
  logic [TotW-1:0]  total_q, total_d;
  logic [ErrW-1:0]  err_q, err_d;
  logic             round_q, round_d, twice_q, twice_d, cur_clone_q, cur_clone_d;
  logic [Alphabet-1:0] rv_q;
  logic             len_lo_q, link_lo_q, tr_inv_q;

  // memory ports
  logic             len_we, link_we, clone_we, lcnt_we, tr_we, log_we;
  logic [NodeW-1:0] len_wa, len_ra, link_wa, link_ra, clone_wa, clone_ra, lcnt_wa, lcnt_ra;
  logic [LenW-1:0]  len_wd, len_rdat, len_eff;
  logic [NodeW-1:0] link_wd, link_rdat, link_eff;
  logic             clone_wd, clone_rdat;
  logic [TopW-1:0]  lcnt_wd, lcnt_rdat;
  logic [TrAw-1:0]  tr_wa, tr_ra;
  logic [NodeW-1:0] tr_wd, tr_rdat, tr_eff;
  logic [LogAw-1:0] log_wa, log_ra;
  logic [LogW-1:0]  log_wd, log_rdat;
  logic [SlotW-1:0] pop_slot, link_slot;
  logic [NodeW-1:0] pop_old;
  logic             ra_root, wa_root;
  logic [ChW-1:0]   ra_idx, wa_idx;
  logic [LenW+1:0]  len_plus2;
  logic [TopW:0]    top_need;

  sads_ram #(.Depth(MaxNodes), .Width(LenW)) u_len (
    .clk_i, .we_i(len_we), .waddr_i(len_wa), .wdata_i(len_wd), .raddr_i(len_ra),
    .rdata_o(len_rdat));
  sads_ram #(.Depth(MaxNodes), .Width(NodeW)) u_link (
    .clk_i, .we_i(link_we), .waddr_i(link_wa), .wdata_i(link_wd), .raddr_i(link_ra),
    .rdata_o(link_rdat));
  sads_ram #(.Depth(MaxNodes), .Width(1)) u_clone (
    .clk_i, .we_i(clone_we), .waddr_i(clone_wa), .wdata_i(clone_wd), .raddr_i(clone_ra),
    .rdata_o(clone_rdat));
  sads_ram #(.Depth(MaxNodes), .Width(TopW)) u_lcnt (
    .clk_i, .we_i(lcnt_we), .waddr_i(lcnt_wa), .wdata_i(lcnt_wd), .raddr_i(lcnt_ra),
    .rdata_o(lcnt_rdat));
  sads_ram #(.Depth(TransWords), .Width(NodeW)) u_trans (
    .clk_i, .we_i(tr_we), .waddr_i(tr_wa), .wdata_i(tr_wd), .raddr_i(tr_ra),
    .rdata_o(tr_rdat));
  sads_ram #(.Depth(LogDepth), .Width(LogW)) u_log (
    .clk_i, .we_i(log_we), .waddr_i(log_wa), .wdata_i(log_wd), .raddr_i(log_ra),
    .rdata_o(log_rdat));

  // root row reads as zero until written; length and link of nodes 0/1 always read as zero
  assign ra_root  = (tr_ra >= TrAw'(Alphabet)) && (tr_ra < TrAw'(2 * Alphabet));
  assign ra_idx   = ChW'(tr_ra - TrAw'(Alphabet));
  assign wa_root  = (tr_wa >= TrAw'(Alphabet)) && (tr_wa < TrAw'(2 * Alphabet));
  assign wa_idx   = ChW'(tr_wa - TrAw'(Alphabet));
  assign len_eff  = len_lo_q ? '0 : len_rdat;
  assign link_eff = link_lo_q ? '0 : link_rdat;
  assign tr_eff   = tr_inv_q ? '0 : tr_rdat;

  assign pop_slot  = log_rdat[LogW-1:NodeW];
  assign pop_old   = log_rdat[NodeW-1:0];
  assign link_slot = SlotW'(TransWords) + SlotW'(q_q);
  assign len_plus2 = (LenW+2)'(len_eff) + (LenW+2)'(2);
  assign top_need  = (TopW+1)'(top_q) + (TopW+1)'(len_plus2);

  // next state, memory commands
  always_comb begin
    st_d = st_q; c_d = c_q; x_d = x_q; y_d = y_q; p_d = p_q; q_d = q_q;
    nc_d = nc_q; last_d = last_q; lenx_d = lenx_q; lenp_d = lenp_q; sub_d = sub_q;
    lennc_d = lennc_q; k_d = k_q; cnt_d = cnt_q; npop_d = npop_q; top_d = top_q;
    total_d = total_q; err_d = err_q; round_d = round_q; twice_d = twice_q;
    cur_clone_d = cur_clone_q;
    len_we = 1'b0; len_wa = '0; len_wd = '0; len_ra = '0;
    link_we = 1'b0; link_wa = '0; link_wd = '0; link_ra = '0;
    clone_we = 1'b0; clone_wa = '0; clone_wd = 1'b0; clone_ra = '0;
    lcnt_we = 1'b0; lcnt_wa = '0; lcnt_wd = '0; lcnt_ra = '0;
    tr_we = 1'b0; tr_wa = '0; tr_wd = '0; tr_ra = '0;
    log_we = 1'b0; log_wa = '0; log_wd = '0; log_ra = '0;
    unique case (st_q)
      S_IDLE: begin
        if (start_i) begin
          c_d   = ChW'(req_i.letter);
          err_d = ErrOk;
          if (req_i.op == OpUndo) begin
            if (nc_q <= NodeW'(1)) begin
              err_d = ErrEmpty;
              st_d  = S_DONE;
            end else begin
              clone_ra = nc_q;
              lcnt_ra  = nc_q;
              round_d  = 1'b0;
              st_d     = S_UHDR;
            end
          end else if (req_i.letter >= LetW'(Alphabet)) begin
            st_d = S_DONE;
          end else begin
            len_ra = last_q;
            st_d   = S_ALEN;
          end
        end
      end
      // capacity check, then open the new node
      S_ALEN: begin
        if (len_eff >= LenW'(MaxLen) ||
            (NodeW+1)'(nc_q) + (NodeW+1)'(2) >= (NodeW+1)'(MaxNodes) ||
            top_need > (TopW+1)'(LogDepth)) begin
          err_d = ErrFull;
          st_d  = S_DONE;
        end else begin
          x_d      = nc_q + NodeW'(1);
          nc_d     = nc_q + NodeW'(1);
          last_d   = nc_q + NodeW'(1);
          p_d      = last_q;
          lenx_d   = len_eff + LenW'(1);
          len_we   = 1'b1;
          len_wa   = nc_q + NodeW'(1);
          len_wd   = len_eff + LenW'(1);
          clone_we = 1'b1;
          clone_wa = nc_q + NodeW'(1);
          clone_wd = 1'b0;
          cnt_d    = '0;
          k_d      = '0;
          st_d     = S_CLR;
        end
      end
      // clear the new node's transition row
      S_CLR: begin
        tr_we = 1'b1;
        tr_wa = trans_addr(x_q, ChW'(k_q));
        tr_wd = '0;
        k_d   = k_q + KW'(1);
        if (k_q == KW'(Alphabet - 1)) st_d = S_W1RD;
      end
      S_W1RD: begin
        if (p_q == '0) begin
          link_we = 1'b1;
          link_wa = x_q;
          link_wd = NodeW'(1);
          sub_d   = '0;
          st_d    = S_AFIN;
        end else begin
          tr_ra   = trans_addr(p_q, c_q);
          link_ra = p_q;
          len_ra  = p_q;
          st_d    = S_W1CK;
        end
      end
      // missing transition: log it and point it at the new node
      S_W1CK: begin
        if (tr_eff == '0) begin
          if (top_q < TopW'(LogDepth)) begin
            log_we = 1'b1;
            log_wa = LogAw'(top_q);
            log_wd = {SlotW'(trans_addr(p_q, c_q)), tr_eff};
            top_d  = top_q + TopW'(1);
            cnt_d  = cnt_q + TopW'(1);
          end
          tr_we = 1'b1;
          tr_wa = trans_addr(p_q, c_q);
          tr_wd = x_q;
          p_d   = link_eff;
          st_d  = S_W1RD;
        end else begin
          q_d    = tr_eff;
          lenp_d = len_eff;
          len_ra = tr_eff;
          st_d   = S_QCK;
        end
      end
      // solid edge or clone
      S_QCK: begin
        if (len_eff == lenp_q + LenW'(1)) begin
          link_we = 1'b1;
          link_wa = x_q;
          link_wd = q_q;
          sub_d   = len_eff;
          st_d    = S_AFIN;
        end else begin
          y_d      = nc_q + NodeW'(1);
          nc_d     = nc_q + NodeW'(1);
          len_we   = 1'b1;
          len_wa   = nc_q + NodeW'(1);
          len_wd   = lenp_q + LenW'(1);
          clone_we = 1'b1;
          clone_wa = nc_q + NodeW'(1);
          clone_wd = 1'b1;
          lcnt_we  = 1'b1;
          lcnt_wa  = x_q;
          lcnt_wd  = cnt_q;
          cnt_d    = '0;
          k_d      = '0;
          sub_d    = lenp_q + LenW'(1);
          st_d     = S_CPY;
        end
      end
      // copy row q into the clone: read one word ahead of the write
      S_CPY: begin
        if (k_q != KW'(Alphabet)) begin
          tr_ra = trans_addr(q_q, ChW'(k_q));
        end else begin
          link_ra = q_q;
          st_d    = S_CLNK;
        end
        if (k_q != '0) begin
          tr_we = 1'b1;
          tr_wa = trans_addr(y_q, ChW'(k_q - KW'(1)));
          tr_wd = tr_eff;
        end
        k_d = k_q + KW'(1);
      end
      S_CLNK: begin
        link_we = 1'b1;
        link_wa = y_q;
        link_wd = link_eff;
        if (top_q < TopW'(LogDepth)) begin
          log_we = 1'b1;
          log_wa = LogAw'(top_q);
          log_wd = {link_slot, link_eff};
          top_d  = top_q + TopW'(1);
          cnt_d  = cnt_q + TopW'(1);
        end
        st_d = S_CLNK2;
      end
      S_CLNK2: begin
        link_we = 1'b1;
        link_wa = q_q;
        link_wd = y_q;
        st_d    = S_XLNK;
      end
      S_XLNK: begin
        link_we = 1'b1;
        link_wa = x_q;
        link_wd = y_q;
        st_d    = S_W2RD;
      end
      S_W2RD: begin
        if (p_q == '0) begin
          st_d = S_AFIN;
        end else begin
          tr_ra   = trans_addr(p_q, c_q);
          link_ra = p_q;
          st_d    = S_W2CK;
        end
      end
      // redirect edges into q over to the clone
      S_W2CK: begin
        if (tr_eff == q_q) begin
          if (top_q < TopW'(LogDepth)) begin
            log_we = 1'b1;
            log_wa = LogAw'(top_q);
            log_wd = {SlotW'(trans_addr(p_q, c_q)), tr_eff};
            top_d  = top_q + TopW'(1);
            cnt_d  = cnt_q + TopW'(1);
          end
          tr_we = 1'b1;
          tr_wa = trans_addr(p_q, c_q);
          tr_wd = y_q;
          p_d   = link_eff;
          st_d  = S_W2RD;
        end else begin
          st_d = S_AFIN;
        end
      end
      S_AFIN: begin
        lcnt_we = 1'b1;
        lcnt_wa = nc_q;
        lcnt_wd = cnt_q;
        total_d = total_q + TotW'(lenx_q) - TotW'(sub_q);
        st_d    = S_DONE;
      end
      // undo: fetch the newest node's header
      S_UHDR: begin
        if (!round_q) twice_d = clone_rdat;
        cur_clone_d = clone_rdat;
        npop_d      = lcnt_rdat;
        st_d        = S_UPOP;
      end
      S_UPOP: begin
        if (npop_q != '0 && top_q != '0) begin
          top_d  = top_q - TopW'(1);
          npop_d = npop_q - TopW'(1);
          log_ra = LogAw'(top_q - TopW'(1));
          st_d   = S_URST;
        end else if (!cur_clone_q) begin
          link_ra = nc_q;
          len_ra  = nc_q;
          st_d    = S_USUBA;
        end else begin
          st_d = S_UNEXT;
        end
      end
      // restore one logged word
      S_URST: begin
        if (pop_slot < SlotW'(TransWords)) begin
          tr_we = 1'b1;
          tr_wa = TrAw'(pop_slot);
          tr_wd = pop_old;
        end else if (pop_slot - SlotW'(TransWords) < SlotW'(MaxNodes)) begin
          link_we = 1'b1;
          link_wa = NodeW'(pop_slot - SlotW'(TransWords));
          link_wd = pop_old;
        end
        st_d = S_UPOP;
      end
      S_USUBA: begin
        lennc_d = len_eff;
        len_ra  = link_eff;
        st_d    = S_USUBB;
      end
      S_USUBB: begin
        total_d = total_q - (TotW'(lennc_q) - TotW'(len_eff));
        st_d    = S_UNEXT;
      end
      S_UNEXT: begin
        nc_d = nc_q - NodeW'(1);
        if (!round_q && twice_q && (nc_q - NodeW'(1)) > NodeW'(1)) begin
          round_d  = 1'b1;
          clone_ra = nc_q - NodeW'(1);
          lcnt_ra  = nc_q - NodeW'(1);
          st_d     = S_UHDR;
        end else begin
          clone_ra = nc_q - NodeW'(1);
          st_d     = S_ULAST;
        end
      end
      S_ULAST: begin
        last_d = (nc_q > NodeW'(1) && clone_rdat) ? nc_q - NodeW'(1) : nc_q;
        st_d   = S_DONE;
      end
      S_DONE: begin
        if (res_ready_i) st_d = S_IDLE;
      end
      default: st_d = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q      <= S_IDLE;
      nc_q      <= NodeW'(1);
      last_q    <= NodeW'(1);
      top_q     <= '0;
      total_q   <= '0;
      rv_q      <= '0;
      len_lo_q  <= 1'b0;
      link_lo_q <= 1'b0;
      tr_inv_q  <= 1'b0;
    end else begin
      st_q      <= st_d;
      nc_q      <= nc_d;
      last_q    <= last_d;
      top_q     <= top_d;
      total_q   <= total_d;
      len_lo_q  <= len_ra < NodeW'(2);
      link_lo_q <= link_ra < NodeW'(2);
      tr_inv_q  <= ra_root && !rv_q[ra_idx];
      if (tr_we && wa_root) rv_q[wa_idx] <= 1'b1;
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    c_q <= c_d; x_q <= x_d; y_q <= y_d; p_q <= p_d; q_q <= q_d;
    lenx_q <= lenx_d; lenp_q <= lenp_d; sub_q <= sub_d; lennc_q <= lennc_d;
    k_q <= k_d; cnt_q <= cnt_d; npop_q <= npop_d; err_q <= err_d;
    round_q <= round_d; twice_q <= twice_d; cur_clone_q <= cur_clone_d;
  end

  assign idle_o      = (st_q == S_IDLE);
  assign res_valid_o = (st_q == S_DONE);
  assign res_o.count = total_q;
  assign res_o.err   = err_q;

endmodule
`default_nettype wire

// ===== hw/rtl/sads_checker.sv =====
// Port-level checks for the suffix automaton top level, and their bind.
// Depends on sads_pkg and suffix_automaton_distinct_substrings.
`timescale 1ns / 1ps
`default_nettype none
module sads_checker (
  input wire        clk_i,
  input wire        rst_ni,
  input wire        s_axis_tvalid,
  input wire        s_axis_tready,
  input wire        m_axis_tvalid,
  input wire        m_axis_tready,
  input wire [23:0] m_axis_tdata,
  input wire [1:0]  m_axis_tuser
);
  import sads_pkg::*;

  // one item in flight: input closes after each transaction
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input accepted while an item is in flight");

  // stalled result holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

  // only defined error codes
  a_err_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tuser == ErrOk || m_axis_tuser == ErrEmpty ||
                      m_axis_tuser == ErrFull)
    else $error("undefined error code");

  // an empty string has no substrings
  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser == ErrEmpty |-> m_axis_tdata == '0)
    else $error("nonzero count on empty string");

endmodule

bind suffix_automaton_distinct_substrings sads_checker u_sads_checker (
  .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .m_axis_tvalid, .m_axis_tready,
  .m_axis_tdata, .m_axis_tuser
);
`default_nettype wire

// ===== dv/tb_top.sv =====
// Self-checking testbench for the suffix automaton distinct-substring counter.
// Depends on sads_pkg and suffix_automaton_distinct_substrings; predicts each
// count with its own automaton model and compares every output transaction.
`timescale 1ns / 1ps
module tb_top;
  import sads_pkg::*;

  localparam int unsigned LimitCycles = 10000000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;
  logic [0:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;

  suffix_automaton_distinct_substrings u_top (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser
  );

  always #6 clk_i = ~clk_i;

  // automaton shadow state
  int unsigned am_next[int];  // key node*Alphabet+ch, absent means zero
  int unsigned am_len[MaxNodes];
  int unsigned am_link[MaxNodes];
  bit          am_clone[MaxNodes];
  int unsigned am_logn[MaxNodes];
  int unsigned jrn_slot[LogDepth];
  int unsigned jrn_old[LogDepth];
  int unsigned jrn_top, am_nodes, am_last;
  logic [23:0] am_total;

  req_t pending_reqs[$];
  res_t count_queue[$];
  int   fails = 0, cycle_cnt = 0, seen = 0, n_full = 0, n_empty = 0;
  bit   stim_done = 0, hold_off = 0, in_acc = 0;

  function automatic int unsigned slot_rd(int unsigned s);
    if (s < TransWords) return am_next.exists(s) ? am_next[s] : 0;
    return am_link[s - TransWords];
  endfunction

  function automatic void slot_wr(int unsigned s, int unsigned v);
    if (s < TransWords) am_next[s] = v;
    else am_link[s - TransWords] = v;
  endfunction

  function automatic void journal_wr(int unsigned s, int unsigned v);
    if (jrn_top < LogDepth && am_nodes < MaxNodes) begin
      jrn_slot[jrn_top] = s;
      jrn_old[jrn_top] = slot_rd(s);
      jrn_top++;
      am_logn[am_nodes]++;
    end
    slot_wr(s, v);
  endfunction

  function automatic logic [ErrW-1:0] extend_by(int unsigned c);
    int unsigned ln, x, p, q, y;
    ln = am_len[am_last];
    if (ln >= MaxLen || am_nodes + 2 >= MaxNodes || jrn_top + ln + 2 > LogDepth)
      return ErrFull;
    x = ++am_nodes;
    p = am_last;
    am_len[x] = ln + 1;
    am_logn[x] = 0;
    am_clone[x] = 0;
    for (int i = 0; i < Alphabet; i++) am_next[x*Alphabet+i] = 0;
    am_last = x;
    while (p != 0 && slot_rd(p*Alphabet+c) == 0) begin
      journal_wr(p*Alphabet+c, x);
      p = am_link[p];
    end
    if (p == 0) am_link[x] = 1;
    else begin
      q = slot_rd(p*Alphabet+c);
      if (am_len[q] == am_len[p] + 1) am_link[x] = q;
      else begin
        y = ++am_nodes;
        am_len[y] = am_len[p] + 1;
        am_clone[y] = 1;
        am_logn[y] = 0;
        for (int i = 0; i < Alphabet; i++) am_next[y*Alphabet+i] = slot_rd(q*Alphabet+i);
        am_link[y] = am_link[q];
        journal_wr(TransWords + q, y);
        am_link[x] = y;
        while (p != 0 && slot_rd(p*Alphabet+c) == q) begin
          journal_wr(p*Alphabet+c, y);
          p = am_link[p];
        end
      end
    end
    am_total = am_total + 24'(am_len[x]) - 24'(am_len[am_link[x]]);
    return ErrOk;
  endfunction

  function automatic logic [ErrW-1:0] retract_last();
    int unsigned rounds, n;
    if (am_nodes <= 1 || am_nodes >= MaxNodes) return ErrEmpty;
    rounds = am_clone[am_nodes] ? 2 : 1;
    for (int r = 0; r < rounds && am_nodes > 1; r++) begin
      n = am_logn[am_nodes];
      for (int i = 0; i < n && jrn_top > 0; i++) begin
        jrn_top--;
        slot_wr(jrn_slot[jrn_top], jrn_old[jrn_top]);
      end
      if (!am_clone[am_nodes])
        am_total = am_total - 24'(am_len[am_nodes] - am_len[am_link[am_nodes]]);
      am_nodes--;
    end
    am_last = am_nodes;
    if (am_clone[am_last] && am_last > 1) am_last--;
    return ErrOk;
  endfunction

  function automatic res_t predict_count(req_t rq);
    res_t r;
    r.err = ErrOk;
    if (rq.op == OpAppend) begin
      if (rq.letter < Alphabet) r.err = extend_by(rq.letter);
    end else r.err = retract_last();
    r.count = am_total;
    return r;
  endfunction

  function automatic void push_req(logic op, logic [4:0] let_v);
    req_t rq;
    rq.op = op;
    rq.letter = let_v;
    pending_reqs.push_back(rq);
  endfunction

  // stimulus
  initial begin
    int kind, n, alpha;
    for (int i = 0; i < MaxNodes; i++) begin
      am_len[i] = 0; am_link[i] = 0; am_clone[i] = 0; am_logn[i] = 0;
    end
    jrn_top = 0; am_nodes = 1; am_last = 1; am_total = '0;
    // directed: undo on empty, extremes, out-of-range letters, clones, undo chains
    push_req(OpUndo, 5'd0);
    push_req(OpAppend, 5'd0);
    push_req(OpAppend, 5'd25);
    push_req(OpAppend, 5'd26);
    push_req(OpAppend, 5'd31);
    push_req(OpAppend, 5'd0);
    push_req(OpAppend, 5'd25);
    push_req(OpAppend, 5'd25);
    push_req(OpAppend, 5'd1);
    push_req(OpUndo, 5'd31);
    push_req(OpAppend, 5'd0);
    push_req(OpAppend, 5'd0);
    for (int i = 0; i < 8; i++) push_req(OpUndo, 5'(i * 4));
    push_req(OpUndo, 5'd15);
    while (pending_reqs.size() < 1200) begin
      kind = $urandom_range(0, 9);
      n = $urandom_range(5, 40);
      alpha = (kind < 5) ? 2 : (kind < 8 ? 4 : 26);
      for (int i = 0; i < n; i++) begin
        if ($urandom_range(0, 3) == 0) push_req(OpUndo, 5'($urandom));
        else if ($urandom_range(0, 40) == 0) push_req(OpAppend, 5'($urandom_range(26, 31)));
        else push_req(OpAppend, 5'($urandom_range(0, alpha - 1)));
      end
    end
    repeat (12) @(posedge clk_i);
    @(negedge clk_i) rst_ni <= 1'b1;
  end

  // note each input handshake at the rising edge
  always @(posedge clk_i) begin
    in_acc <= rst_ni && s_axis_tvalid && s_axis_tready;
  end

  // driver: bursts and gaps
  int gap_left = 0, burst_left = 8;
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && !in_acc) begin
        // hold current transaction
      end else if (gap_left > 0) begin
        s_axis_tvalid <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (pending_reqs.size() > 0) begin
        req_t rq;
        rq = pending_reqs.pop_front();
        count_queue.push_back(predict_count(rq));
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= rq.op;
        s_axis_tdata <= {3'b000, rq.letter};
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 30);
          gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 100);
        end else burst_left <= burst_left - 1;
      end else begin
        s_axis_tvalid <= 1'b0;
        stim_done <= 1'b1;
      end
    end
  end

  // receiver stall pattern, with one long hold-off early in the run
  int stall_phase = 0, hold_cnt = 0;
  always @(negedge clk_i) begin
    if (rst_ni) begin
      stall_phase <= stall_phase + 1;
      if (seen == 30 && hold_cnt == 0) begin
        hold_off <= 1'b1;
        hold_cnt <= 1;
      end else if (hold_off) begin
        hold_cnt <= hold_cnt + 1;
        if (hold_cnt > 3000) hold_off <= 1'b0;
      end
      if (hold_off) m_axis_tready <= 1'b0;
      else if ((stall_phase / 2000) % 3 == 0) m_axis_tready <= 1'b1;
      else m_axis_tready <= ($urandom_range(0, 99) < 60);
    end
  end

  // monitor
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      res_t exp_r;
      if (count_queue.size() == 0) begin
        $error("unexpected output transaction: distinct_count %0d", m_axis_tdata);
        fails++;
      end else begin
        exp_r = count_queue.pop_front();
        seen++;
        if (exp_r.err == ErrFull) n_full++;
        if (exp_r.err == ErrEmpty) n_empty++;
        if (m_axis_tdata !== exp_r.count) begin
          $error("distinct_count: expected %0d, actual %0d", exp_r.count, m_axis_tdata);
          fails++;
        end
        if (m_axis_tuser !== exp_r.err) begin
          $error("error: expected %0d, actual %0d", exp_r.err, m_axis_tuser);
          fails++;
        end
      end
    end
  end

  // end of run and timeout
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= LimitCycles) begin
      $display("timeout after %0d cycles, %0d results pending", cycle_cnt, count_queue.size());
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    wait (stim_done && count_queue.size() == 0);
    repeat (200) @(posedge clk_i);
    $display("checked %0d output transactions (%0d undo-on-empty, %0d full-string)",
             seen, n_empty, n_full);
    $display("covered letter extremes, ignored letters, clones, undo chains and a long stall");
    if (fails == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule
